>>> hdl/art_pkg.sv
`default_nettype none
package art_pkg;

   localparam int MAX_REGIONS_DEF = 16;
   localparam int PAGE_W = 20;
   localparam int END_W = 21;
   localparam int COUNT_W = 21;
   localparam int ADDR_W = 32;
   localparam int OFF_W = 12;
   localparam logic [21:0] PAGE_LIMIT = 22'h100000;

   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_ALLOC = 3'd1,
      KIND_FREE = 3'd2,
      KIND_V2P = 3'd3,
      KIND_P2V = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL = 3'd2,
      ST_EXCEEDED = 3'd3,
      ST_ZERO = 3'd4
   } status_type;

   typedef struct packed {
      logic [PAGE_W-1:0] phys_base;
      logic [END_W-1:0] virt_end;
      logic [PAGE_W-1:0] virt_begin;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

>>> hdl/art_ram.sv
`default_nettype none
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/address_region_table.sv
`default_nettype none
// Channel   Dir  Handshake              Payload
// request   in   req_tvalid/req_tready  tuser kind, tdata address/phys_address/page_count
// response  out  rsp_tvalid/rsp_tready  tuser status, tdata result_address
// csr       in   csr_write_enable       csr_write_data alloc_start_page
// One request at a time. A lookup scans the entries one by one through the
// registered table memory; insert, alloc and free also move entries one at a
// time to open or close a slot. Reset clears the region count; entries need no
// clearing. A held response does not block the next request, but that
// request's response waits until the held one is taken.
module address_region_table #(
   parameter int MAX_REGIONS = art_pkg::MAX_REGIONS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [87:0] req_tdata,   // address, phys_address, page_count, zero pad
   input wire logic [2:0] req_tuser,    // kind
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [31:0] rsp_tdata,       // result_address
   output logic [2:0] rsp_tuser,        // status
   input wire logic csr_write_enable,
   input wire logic [19:0] csr_write_data
);

   import art_pkg::*;

   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int IW = $clog2(MAX_REGIONS);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_RD   = 9'b000000010,
      S_EV   = 9'b000000100,
      S_ARD  = 9'b000001000,
      S_AEV  = 9'b000010000,
      S_MVRD = 9'b000100000,
      S_MVWR = 9'b001000000,
      S_PUT  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, paddr_ff, paddr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, pos_ff, pos_in;
   logic [END_W-1:0] nb_ff, nb_in;
   entry_type new_ff, new_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   status_type st_ff, st_in;
   logic [PAGE_W-1:0] start_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_user_ff, rsp_user_in;

   logic wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   logic [PAGE_W-1:0] vpage, ppage;
   logic hit_virt, hit_phys, last_pair, overlap, shift_down;
   logic [21:0] ne, pend;
   logic [CW:0] idx_p1, idx_p2;

   art_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign vpage = addr_ff[ADDR_W-1:OFF_W];
   assign ppage = paddr_ff[ADDR_W-1:OFF_W];
   assign shift_down = (kind_ff == KIND_FREE);
   assign idx_p1 = {1'b0, idx_ff} + 1'b1;
   assign idx_p2 = {1'b0, idx_ff} + 2'd2;
   assign hit_virt = (vpage >= rd_data.virt_begin) && ({1'b0, vpage} < rd_data.virt_end);
   assign pend = (rd_data.virt_end >= {1'b0, rd_data.virt_begin}) ?
                 22'(rd_data.phys_base) + 22'(rd_data.virt_end)
                 - 22'(rd_data.virt_begin) : 22'(rd_data.phys_base);
   assign hit_phys = (ppage >= rd_data.phys_base) && (22'(ppage) < pend);
   assign ne = 22'(nb_ff) + 22'(cnt_ff);
   assign last_pair = (idx_p1 >= {1'b0, count_ff});
   assign overlap = (nb_ff < rd_data.virt_end) && (22'(rd_data.virt_begin) < ne);

   always_comb begin
      rd_addr = idx_ff[IW-1:0];
      case (state_ff)
         S_ARD: rd_addr = idx_p1[IW-1:0];
         S_MVRD: rd_addr = shift_down ? idx_p1[IW-1:0] : IW'(idx_ff - 1'b1);
         default: rd_addr = idx_ff[IW-1:0];
      endcase
      wr_en = (state_ff == S_MVWR) || (state_ff == S_PUT);
      wr_addr = (state_ff == S_PUT) ? pos_ff[IW-1:0] : idx_ff[IW-1:0];
      wr_data = (state_ff == S_PUT) ? new_ff : rd_data;
   end

   always_comb begin
      logic [21:0] pend_in, vend_in;
      logic decide;
      logic [CW-1:0] up_pos;
      pend_in = 22'(req_tdata[63:44]) + 22'(req_tdata[84:64]);
      vend_in = 22'(req_tdata[31:12]) + 22'(req_tdata[84:64]);
      decide = 1'b0;
      up_pos = '0;
      state_in = state_ff;
      kind_in = kind_ff;
      addr_in = addr_ff;
      paddr_in = paddr_ff;
      cnt_in = cnt_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      nb_in = nb_ff;
      new_in = new_ff;
      res_in = res_ff;
      st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               addr_in = req_tdata[31:0];
               paddr_in = req_tdata[63:32];
               cnt_in = req_tdata[84:64];
               idx_in = '0;
               res_in = '0;
               st_in = ST_NOT_FOUND;
               state_in = S_RD;
               if (req_tuser == KIND_INSERT || req_tuser == KIND_ALLOC) begin
                  if (req_tdata[84:64] == '0) begin
                     st_in = ST_ZERO;
                     state_in = S_DONE;
                  end else if (count_ff >= MAX_CNT) begin
                     st_in = ST_FULL;
                     state_in = S_DONE;
                  end else if (pend_in > PAGE_LIMIT ||
                               (req_tuser == KIND_INSERT && vend_in > PAGE_LIMIT)) begin
                     st_in = ST_EXCEEDED;
                     state_in = S_DONE;
                  end
               end else if (req_tuser != KIND_FREE && req_tuser != KIND_V2P &&
                            req_tuser != KIND_P2V) begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               if (kind_ff == KIND_INSERT) begin
                  new_in = '{phys_base: ppage, virt_end: END_W'(22'(vpage) + 22'(cnt_ff)),
                             virt_begin: vpage};
                  pos_in = count_ff;
                  idx_in = count_ff;
                  state_in = S_PUT;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            idx_in = CW'(idx_p1);
            state_in = S_RD;
            case (kind_ff)
               KIND_INSERT: begin
                  if (vpage <= rd_data.virt_begin) begin
                     new_in = '{phys_base: ppage,
                                virt_end: END_W'(22'(vpage) + 22'(cnt_ff)),
                                virt_begin: vpage};
                     pos_in = idx_ff;
                     idx_in = count_ff;
                     state_in = (count_ff > idx_ff) ? S_MVRD : S_PUT;
                  end
               end
               KIND_ALLOC: begin
                  if (rd_data.virt_begin >= start_ff) begin
                     nb_in = rd_data.virt_end;
                     idx_in = idx_ff;
                     state_in = S_ARD;
                  end
               end
               KIND_FREE: begin
                  if (hit_virt) begin
                     pos_in = idx_ff;
                     idx_in = idx_ff;
                     if (idx_p1 < {1'b0, count_ff}) begin
                        state_in = S_MVRD;
                     end else begin
                        count_in = count_ff - 1'b1;
                        st_in = ST_OK;
                        state_in = S_DONE;
                     end
                  end
               end
               KIND_V2P: begin
                  if (hit_virt) begin
                     res_in = addr_ff - {rd_data.virt_begin, 12'h000}
                              + {rd_data.phys_base, 12'h000};
                     st_in = ST_OK;
                     state_in = S_DONE;
                  end
               end
               KIND_P2V: begin
                  if (hit_phys) begin
                     res_in = addr_ff - {rd_data.phys_base, 12'h000}
                              + {rd_data.virt_begin, 12'h000};
                     st_in = ST_OK;
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_ARD: begin
            if (last_pair) begin
               decide = 1'b1;
            end else begin
               state_in = S_AEV;
            end
         end
         S_AEV: begin
            if (overlap) begin
               idx_in = CW'(idx_p1);
               nb_in = rd_data.virt_end;
               state_in = S_ARD;
            end else begin
               decide = 1'b1;
            end
         end
         S_MVRD: state_in = S_MVWR;
         S_MVWR: begin
            if (shift_down) begin
               idx_in = CW'(idx_p1);
               if (idx_p2 < {1'b0, count_ff}) begin
                  state_in = S_MVRD;
               end else begin
                  count_in = count_ff - 1'b1;
                  st_in = ST_OK;
                  state_in = S_DONE;
               end
            end else begin
               idx_in = idx_ff - 1'b1;
               state_in = ((idx_ff - 1'b1) > pos_ff) ? S_MVRD : S_PUT;
            end
         end
         S_PUT: begin
            count_in = count_ff + 1'b1;
            st_in = ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               rsp_user_in = st_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // The alloc candidate right after the current region is accepted, unless it runs past the page limit.
      if (decide) begin
         up_pos = CW'(idx_p1);
         if (ne > PAGE_LIMIT) begin
            st_in = ST_EXCEEDED;
            state_in = S_DONE;
         end else begin
            new_in = '{phys_base: ppage, virt_end: END_W'(ne), virt_begin: nb_ff[19:0]};
            res_in = {nb_ff[19:0], paddr_ff[11:0]};
            pos_in = up_pos;
            idx_in = count_ff;
            state_in = (count_ff > up_pos) ? S_MVRD : S_PUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            start_ff <= csr_write_data;
         end
      end
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      paddr_ff <= paddr_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      nb_ff <= nb_in;
      new_ff <= new_in;
      res_ff <= res_in;
      st_ff <= st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("region count above table size");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");
   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MVWR) |-> (idx_ff < MAX_CNT))
      else $error("entry move outside table");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) != S_IDLE))
      else $error("region count changed while idle");
`endif

endmodule
`default_nettype wire

>>> test/tb.sv
module tb;
   import art_pkg::*;

   localparam int MAXR = art_pkg::MAX_REGIONS_DEF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [31:0] result_address;
      logic [2:0] status;
   } rsp_item_type;

   class region_scoreboard;
      logic [31:0] vb[MAXR];
      logic [31:0] ve[MAXR];
      logic [31:0] pb[MAXR];
      int used;
      logic [19:0] start_page;
      rsp_item_type pending_rsp[$];
      int errors;
      int checked;

      function new();
         used = 0;
         start_page = '0;
         errors = 0;
         checked = 0;
      endfunction

      task report(string msg);
         $display("mismatch %0d: %s", errors, msg);
         errors++;
      endtask

      function void put_at(int pos, logic [31:0] b, logic [31:0] e, logic [31:0] p);
         for (int k = used; k > pos; k--) begin
            vb[k] = vb[k-1];
            ve[k] = ve[k-1];
            pb[k] = pb[k-1];
         end
         vb[pos] = b;
         ve[pos] = e;
         pb[pos] = p;
         used++;
      endfunction

      function void drop_at(int pos);
         for (int k = pos; k + 1 < used; k++) begin
            vb[k] = vb[k+1];
            ve[k] = ve[k+1];
            pb[k] = pb[k+1];
         end
         used--;
      endfunction

      function int find_virt(logic [31:0] page);
         for (int k = 0; k < used; k++)
            if (page >= vb[k] && page < ve[k]) return k;
         return used;
      endfunction

      function void note_request(logic [2:0] kind, logic [31:0] addr, logic [31:0] paddr,
                                 logic [20:0] cnt);
         logic [31:0] vpage, ppage, nb, ne, len;
         logic [63:0] off, full;
         rsp_item_type e;
         int i;
         vpage = addr >> 12;
         ppage = paddr >> 12;
         e.result_address = '0;
         e.status = ST_NOT_FOUND;
         if (kind == KIND_INSERT || kind == KIND_ALLOC) begin
            if (cnt == 0) begin
               e.status = ST_ZERO;
            end else if (used >= MAXR) begin
               e.status = ST_FULL;
            end else if (ppage + cnt > 32'h100000 ||
                         (kind == KIND_INSERT && vpage + cnt > 32'h100000)) begin
               e.status = ST_EXCEEDED;
            end else if (kind == KIND_INSERT) begin
               i = 0;
               while (i < used && vpage > vb[i]) i++;
               put_at(i, vpage, vpage + cnt, ppage);
               e.status = ST_OK;
            end else begin
               i = 0;
               while (i < used && vb[i] < {12'b0, start_page}) i++;
               while (i < used) begin
                  nb = ve[i];
                  ne = nb + cnt;
                  // A candidate that overlaps the next region moves the search on.
                  if (i + 1 < used && nb < ve[i+1] && vb[i+1] < ne) begin
                     i++;
                  end else begin
                     if (ne > 32'h100000) begin
                        e.status = ST_EXCEEDED;
                     end else begin
                        put_at(i + 1, nb, ne, ppage);
                        e.result_address = (nb << 12) | {20'b0, paddr[11:0]};
                        e.status = ST_OK;
                     end
                     break;
                  end
               end
            end
         end else if (kind == KIND_FREE) begin
            i = find_virt(vpage);
            if (i < used) begin
               drop_at(i);
               e.status = ST_OK;
            end
         end else if (kind == KIND_V2P) begin
            i = find_virt(vpage);
            if (i < used) begin
               off = {32'b0, addr} - ({32'b0, vb[i]} << 12);
               full = ({32'b0, pb[i]} << 12) + off;
               e.result_address = full[31:0];
               e.status = ST_OK;
            end
         end else if (kind == KIND_P2V) begin
            for (i = 0; i < used; i++) begin
               len = (ve[i] < vb[i]) ? 32'd0 : ve[i] - vb[i];
               if (ppage >= pb[i] && ppage < pb[i] + len) begin
                  off = {32'b0, addr} - ({32'b0, pb[i]} << 12);
                  full = ({32'b0, vb[i]} << 12) + off;
                  e.result_address = full[31:0];
                  e.status = ST_OK;
                  break;
               end
            end
         end
         pending_rsp.push_back(e);
      endfunction

      task check_response(logic [31:0] res, logic [2:0] st);
         rsp_item_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected response addr=%h status=%0d", res, st));
         end else begin
            e = pending_rsp.pop_front();
            if (res !== e.result_address)
               report($sformatf("result_address %h, wanted %h", res, e.result_address));
            if (st !== e.status)
               report($sformatf("status %0d, wanted %0d", st, e.status));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [87:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_write_enable = 0;
   logic [19:0] csr_write_data = '0;

   region_scoreboard sb = new();
   int sent = 0;
   int kind_seen[8];
   bit no_gaps = 0;

   address_region_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task send_request(logic [2:0] kind, logic [31:0] addr, logic [31:0] paddr,
                     logic [20:0] cnt);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {3'b0, cnt, paddr, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, addr, paddr, cnt);
      kind_seen[kind]++;
      sent++;
   endtask

   task drain_and_write(logic [19:0] value);
      req_tvalid <= 0;
      while (sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (4 * MAXR + 10) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.start_page = value;
   endtask

   function automatic logic [31:0] pick_vaddr();
      int i;
      logic [31:0] page;
      if (sb.used > 0 && $urandom_range(0, 9) < 7) begin
         i = $urandom_range(0, sb.used - 1);
         page = sb.vb[i] + $urandom_range(0, sb.ve[i] - sb.vb[i]);
         return {page[19:0], 12'($urandom())};
      end
      if ($urandom_range(0, 9) < 2) return $urandom();
      return {20'($urandom_range(0, 80)), 12'($urandom())};
   endfunction

   function automatic logic [31:0] pick_paddr();
      int i;
      if (sb.used > 0 && $urandom_range(0, 9) < 6) begin
         i = $urandom_range(0, sb.used - 1);
         return {20'(sb.pb[i] + $urandom_range(0, 3)), 12'($urandom())};
      end
      if ($urandom_range(0, 9) < 2) return $urandom();
      return {20'($urandom_range(0, 200)), 12'($urandom())};
   endfunction

   function automatic logic [20:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return 21'($urandom());
      if (r < 10) return 21'h100000;
      return 21'($urandom_range(1, 8));
   endfunction

   task random_request();
      int r;
      logic [2:0] kind;
      r = $urandom_range(0, 99);
      // Keep the table churning: fill when sparse, free more when nearly full.
      if (r < 3) kind = 3'($urandom_range(5, 7));
      else if (r < (sb.used > 12 ? 15 : 30)) kind = KIND_INSERT;
      else if (r < (sb.used > 12 ? 30 : 50)) kind = KIND_ALLOC;
      else if (r < (sb.used > 12 ? 65 : 63)) kind = KIND_FREE;
      else if (r < 82) kind = KIND_V2P;
      else kind = KIND_P2V;
      if (kind == KIND_P2V) send_request(kind, pick_paddr(), $urandom(), pick_count());
      else send_request(kind, pick_vaddr(), pick_paddr(), pick_count());
   endtask

   initial begin
      logic [19:0] settings[5];
      settings = '{20'h00000, 20'hFFFFF, 20'h00010, 20'($urandom()), 20'h00003};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: every kind, edge pages, zero count, both overflow cases, misses.
      send_request(KIND_INSERT, 32'h0000_1000, 32'h0000_5000, 21'd0);
      send_request(KIND_V2P, 32'h0000_1234, 32'h0, 21'd1);
      send_request(KIND_ALLOC, 32'h0, 32'h0000_0ABC, 21'd1);
      send_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 21'h100000);
      send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_F000, 21'd1);
      send_request(KIND_INSERT, 32'hFFFF_F000, 32'h0, 21'd2);
      send_request(KIND_INSERT, 32'h0, 32'hFFFF_F000, 21'd2);
      send_request(KIND_INSERT, 32'h0, 32'h0, 21'h1FFFFF);
      send_request(KIND_V2P, 32'hFFFF_FFFF, 32'h0, 21'd1);
      send_request(KIND_V2P, 32'h0012_3456, 32'h0, 21'd1);
      send_request(KIND_P2V, 32'hFFFF_FABC, 32'h0, 21'd1);
      send_request(KIND_P2V, 32'h0000_0001, 32'h0, 21'd1);
      send_request(KIND_ALLOC, 32'h0, 32'hFFFF_FFFF, 21'd1);
      send_request(KIND_FREE, 32'hFFFF_F000, 32'h0, 21'd0);
      send_request(KIND_FREE, 32'h0000_0000, 32'h0, 21'd0);
      send_request(KIND_FREE, 32'h0000_0000, 32'h0, 21'd0);
      send_request(KIND_INSERT, 32'h0000_4000, 32'h0004_0000, 21'd4);
      send_request(KIND_INSERT, 32'h0000_2000, 32'h0003_0000, 21'd2);
      send_request(KIND_ALLOC, 32'h0, 32'h0009_0123, 21'd3);
      send_request(KIND_P2V, 32'h0004_1FFF, 32'h0, 21'd1);
      send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'h1FFFFF);
      send_request(3'd7, 32'h0, 32'h0, 21'd1);

      for (int ph = 0; ph < 5; ph++) begin
         drain_and_write(settings[ph]);
         no_gaps = (ph == 2);
         repeat (340) random_request();
      end
      req_tvalid <= 0;
      while (sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (4 * MAXR + 10) @(posedge clock);

      $display("%0d requests (insert %0d, alloc %0d, free %0d, v2p %0d, p2v %0d, other %0d)",
               sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
               kind_seen[5] + kind_seen[6] + kind_seen[7]);
      $display("%0d responses checked over 5 allocation start settings, %0d mismatches",
               sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Response side: random stalls, mostly short, occasionally long.
   initial begin
      int stall;
      stall = 0;
      forever begin
         if (stall > 0) begin
            rsp_tready <= 0;
            stall--;
         end else begin
            rsp_tready <= 1;
            if (!no_gaps && $urandom_range(0, 99) < 25)
               stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 50);
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule

>>> filelist.f
hdl/art_pkg.sv
hdl/art_ram.sv
hdl/address_region_table.sv
test/tb.sv
